// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the transcoder RTL.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/u8u16_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 to UTF-16 transcoder.
// Depends on nothing; used by every module of the block.
package u8u16_pkg;

    localparam logic [10:0] MAX_UNITS = 11'd2046;
    localparam logic [10:0] UNITS_CAP = 11'h7FF;
    localparam logic [6:0]  QMARK     = 7'h3F;
    localparam int          QDEPTH    = 4;
    localparam int          QAW       = $clog2(QDEPTH);

    // One request from the front: an optional code point, then an optional short unit
    typedef struct packed {
        logic        pa_en;
        logic [20:0] pa;
        logic        sb_en;
        logic [6:0]  sb_unit;
        logic        sb_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [10:0] f_sat_add(input logic [10:0] a, input logic [1:0] n);
        logic [11:0] s;
        s = {1'b0, a} + {10'b0, n};
        return s[11] ? UNITS_CAP : s[10:0];
    endfunction

    // Units a code point expands to: two for a surrogate pair
    function automatic logic [1:0] f_units(input logic [20:0] cp);
        return (cp[20:16] != 5'd0) ? 2'd2 : 2'd1;
    endfunction

endpackage

// ===== rtl/u8u16_front.sv =====
// Front of the transcoder: classifies each byte, keeps the sequence state and
// the unit count, and builds at most one request per byte. Depends on u8u16_pkg.
module u8u16_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte,
    input  logic              i_accept,
    output u8u16_pkg::t_cmd   o_cmd,
    output logic              o_cmd_en
);

    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_rem, n_rem;
    logic [10:0] r_cnt, n_cnt;
    logic [10:0] cnt_mid;
    logic [20:0] shifted;
    u8u16_pkg::t_cmd cmd;

    always_comb begin
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        cnt_mid = r_cnt;
        shifted = {r_acc[14:0], i_byte[5:0]};
        cmd     = '0;
        if (i_byte == 8'd0) begin
            // flush any pending sequence, then terminate and clear
            cmd.pa_en   = (r_rem != 2'd0);
            cmd.pa      = r_acc;
            cmd.sb_en   = 1'b1;
            cmd.sb_unit = 7'd0;
            cmd.sb_last = 1'b1;
            n_acc = '0;
            n_rem = '0;
            n_cnt = '0;
        end else if (r_rem != 2'd0 && i_byte[7:6] == 2'b10) begin
            n_rem = r_rem - 2'd1;
            if (r_rem == 2'd1) begin
                cmd.pa_en = 1'b1;
                cmd.pa    = shifted;
                n_acc     = '0;
                n_cnt     = u8u16_pkg::f_sat_add(r_cnt, u8u16_pkg::f_units(shifted));
            end else begin
                n_acc = shifted;
            end
        end else begin
            if (r_rem != 2'd0) begin
                // sequence cut short: emit what was gathered
                cmd.pa_en = 1'b1;
                cmd.pa    = r_acc;
                n_acc     = '0;
                n_rem     = '0;
                cnt_mid   = u8u16_pkg::f_sat_add(r_cnt, u8u16_pkg::f_units(r_acc));
            end
            n_cnt = cnt_mid;
            // at the limit, drop the byte, whatever its kind
            if (cnt_mid < u8u16_pkg::MAX_UNITS) begin
                if (!i_byte[7]) begin
                    cmd.sb_en   = 1'b1;
                    cmd.sb_unit = i_byte[6:0];
                    n_cnt       = u8u16_pkg::f_sat_add(cnt_mid, 2'd1);
                end else if (i_byte[7:5] == 3'b110) begin
                    n_acc = {16'd0, i_byte[4:0]};
                    n_rem = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_acc = {17'd0, i_byte[3:0]};
                    n_rem = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_acc = {18'd0, i_byte[2:0]};
                    n_rem = 2'd3;
                end else begin
                    cmd.sb_en   = 1'b1;
                    cmd.sb_unit = u8u16_pkg::QMARK;
                    n_cnt       = u8u16_pkg::f_sat_add(cnt_mid, 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
        end
    end

    assign o_cmd    = cmd;
    assign o_cmd_en = cmd.pa_en | cmd.sb_en;

endmodule

// ===== rtl/u8u16_queue.sv =====
// Short request queue between front and back of the transcoder.
// Depends on u8u16_pkg.
module u8u16_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  u8u16_pkg::t_cmd      i_wr_data,
    input  logic                 i_rd,
    output u8u16_pkg::t_cmd      o_rd_data,
    output u8u16_pkg::t_qstat    o_stat
);

    u8u16_pkg::t_cmd r_mem [u8u16_pkg::QDEPTH];
    logic [u8u16_pkg::QAW-1:0] r_wp, r_rp;
    logic [u8u16_pkg::QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (u8u16_pkg::QAW+1)'(i_wr) - (u8u16_pkg::QAW+1)'(i_rd);
        end
    end

    assign o_rd_data    = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/u8u16_back.sv =====
// Back of the transcoder: takes requests from the queue and presents their
// UTF-16 units one at a time, splitting surrogate pairs. Depends on u8u16_pkg.
`include "assert_macros.svh"
module u8u16_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8u16_pkg::t_qstat   i_qstat,
    input  u8u16_pkg::t_cmd     i_qdata,
    output logic                o_qrd,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [15:0]         o_code_unit,
    output logic                o_end_of_string
);

    typedef enum logic [1:0] {ST_IDLE, ST_POINT, ST_LOW, ST_SECOND} t_state;

    t_state          r_state, n_state, after;
    u8u16_pkg::t_cmd r_cmd;
    logic            surr;
    logic            last_unit;
    logic            load;
    logic [20:0]     v;

    assign surr = (r_cmd.pa[20:16] != 5'd0);
    assign v    = r_cmd.pa - 21'h10000;

    always_comb begin
        after = ST_IDLE;
        case (r_state)
            ST_POINT:  after = surr ? ST_LOW : (r_cmd.sb_en ? ST_SECOND : ST_IDLE);
            ST_LOW:    after = r_cmd.sb_en ? ST_SECOND : ST_IDLE;
            default:   after = ST_IDLE;
        endcase
    end

    assign last_unit = (after == ST_IDLE);
    assign load      = !i_qstat.empty && (r_state == ST_IDLE || (i_pop && last_unit));
    assign o_qrd     = load;

    always_comb begin
        n_state = r_state;
        if (load) begin
            n_state = i_qdata.pa_en ? ST_POINT : ST_SECOND;
        end else if (r_state != ST_IDLE && i_pop) begin
            n_state = after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (load) begin
            r_cmd <= i_qdata;
        end
    end

    always_comb begin
        case (r_state)
            ST_POINT:  o_code_unit = surr ? (16'hD800 | {5'd0, v[20:10]}) : r_cmd.pa[15:0];
            ST_LOW:    o_code_unit = 16'hDC00 | {6'd0, v[9:0]};
            ST_SECOND: o_code_unit = {9'd0, r_cmd.sb_unit};
            default:   o_code_unit = 16'd0;
        endcase
    end

    assign o_empty         = (r_state == ST_IDLE);
    assign o_end_of_string = (r_state == ST_SECOND) && r_cmd.sb_last;

    `ASSERT_CLK(a_low_is_pair, i_clk, i_rst_n, (r_state == ST_LOW) |-> (r_cmd.pa_en && surr), "low surrogate without a pair")
    `ASSERT_CLK(a_second_en, i_clk, i_rst_n, (r_state == ST_SECOND) |-> r_cmd.sb_en, "second unit not requested")
    `ASSERT_NEVER(a_rd_empty, i_clk, i_rst_n, o_qrd && i_qstat.empty, "read from empty queue")
    `ASSERT_CLK(a_eos_zero, i_clk, i_rst_n, o_end_of_string |-> (o_code_unit == 16'd0), "terminator not zero")

endmodule

// ===== rtl/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder: front, request queue, back.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
//
//  channel | ports                          | accepted when
//  --------+--------------------------------+-------------------
//  bytes   | i_in_byte, push, full          | push && !full
//  units   | o_code_unit, o_end_of_string,  | pop && !empty
//          | empty, pop                     |
//
// One byte is taken per cycle while the four-entry request queue has room.
// The back presents one unit per cycle while pop is high; a byte yielding two or
// three units holds the back for each of them and the queue absorbs the difference.
// At the earliest, a unit shows once its request has passed the queue and r_cmd.
// Reset is synchronous and clears the sequence state, the count and the queue.
module utf8_to_utf16_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_in_byte,
    input  logic        push,
    output logic        full,
    output logic [15:0] o_code_unit,
    output logic        o_end_of_string,
    output logic        empty,
    input  logic        pop
);

    u8u16_pkg::t_cmd   cmd, qdata;
    u8u16_pkg::t_qstat qstat;
    logic              cmd_en;
    logic              accept;
    logic              qrd;

    assign accept = push && !qstat.full;
    assign full   = qstat.full;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_in_byte),
        .i_accept (accept),
        .o_cmd    (cmd),
        .o_cmd_en (cmd_en)
    );

    u8u16_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept && cmd_en),
        .i_wr_data (cmd),
        .i_rd      (qrd),
        .o_rd_data (qdata),
        .o_stat    (qstat)
    );

    u8u16_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_qdata         (qdata),
        .o_qrd           (qrd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_code_unit     (o_code_unit),
        .o_end_of_string (o_end_of_string)
    );

endmodule

// ===== tb/utf16_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UTF-8 to UTF-16 transcoder: watches the byte and unit channels,
// predicts the code units of every accepted byte and compares them in order.
// Depends on nothing but the port list of utf8_to_utf16_decoder.
module utf16_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_in_byte,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] o_code_unit,
    input  logic        o_end_of_string,
    input  logic        empty,
    input  logic        pop,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [10:0] UNIT_LIMIT         = 11'd2046;
    localparam logic [10:0] UNIT_COUNT_CAP     = 11'd2047;
    localparam logic [15:0] QUESTION_MARK      = 16'h003F;
    localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
    localparam logic [15:0] LOW_SURROGATE      = 16'hDC00;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
    } t_utf16_unit;

    t_utf16_unit expected_units[$];

    logic [20:0] code_point_acc;
    logic [1:0]  cont_left;
    logic [10:0] unit_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic queue_unit(input logic [15:0] unit, input logic last);
        t_utf16_unit u;
        u.code_unit = unit;
        u.last      = last;
        expected_units.push_back(u);
        if (!last && unit_count != UNIT_COUNT_CAP)
            unit_count = unit_count + 11'd1;
    endtask

    task automatic queue_code_point(input logic [20:0] cp);
        logic [31:0] offset;
        logic [31:0] hi;
        logic [31:0] lo;
        if (cp >= SUPPLEMENTARY_BASE) begin
            offset = {11'd0, cp} - {11'd0, SUPPLEMENTARY_BASE};
            hi = {16'd0, HIGH_SURROGATE} | (offset >> 10);
            lo = {16'd0, LOW_SURROGATE} | (offset & 32'h3FF);
            queue_unit(hi[15:0], 1'b0);
            queue_unit(lo[15:0], 1'b0);
        end else begin
            queue_unit(cp[15:0], 1'b0);
        end
    endtask

    task automatic start_sequence(input logic [7:0] b);
        // drop every new byte once the string is at its unit limit
        if (unit_count >= UNIT_LIMIT)
            return;
        casez (b)
            8'b0???????: queue_code_point({13'd0, b});
            8'b110?????: begin
                code_point_acc = {16'd0, b[4:0]};
                cont_left      = 2'd1;
            end
            8'b1110????: begin
                code_point_acc = {17'd0, b[3:0]};
                cont_left      = 2'd2;
            end
            8'b11110???: begin
                code_point_acc = {18'd0, b[2:0]};
                cont_left      = 2'd3;
            end
            default: queue_code_point({5'd0, QUESTION_MARK});
        endcase
    endtask

    task automatic decode_utf8_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            // flush a pending sequence, then terminate and clear
            if (cont_left != 2'd0)
                queue_code_point(code_point_acc);
            queue_unit(16'h0000, 1'b1);
            code_point_acc = '0;
            cont_left      = '0;
            unit_count     = '0;
            return;
        end
        if (cont_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                code_point_acc = {code_point_acc[14:0], b[5:0]};
                cont_left      = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    queue_code_point(code_point_acc);
                    code_point_acc = '0;
                end
                return;
            end
            // cut short: emit what was gathered and restart on this byte
            queue_code_point(code_point_acc);
            code_point_acc = '0;
            cont_left      = '0;
        end
        start_sequence(b);
    endtask

    always @(posedge i_clk) begin
        t_utf16_unit want;
        if (!i_rst_n) begin
            expected_units.delete();
            code_point_acc = '0;
            cont_left      = '0;
            unit_count     = '0;
        end else begin
            // compare before predicting: a unit never leaves on its own byte's edge
            if (pop && !empty) begin
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected unit %h last %b", $time,
                             o_code_unit, o_end_of_string);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_units.pop_front();
                    if (o_code_unit !== want.code_unit) begin
                        $display("%0t: code_unit expected %h, got %h", $time,
                                 want.code_unit, o_code_unit);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (o_end_of_string !== want.last) begin
                        $display("%0t: end_of_string expected %b, got %b", $time,
                                 want.last, o_end_of_string);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (push && !full)
                decode_utf8_byte(i_in_byte);
        end
        o_pending <= expected_units.size();
    end

endmodule

// ===== tb/utf8_to_utf16_decoder_test.sv =====
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, byte stimulus and unit pops.
// Depends on utf8_to_utf16_decoder and utf16_unit_checker.
module utf8_to_utf16_decoder_test;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] o_code_unit;
    logic        o_end_of_string;

    int fail_count;
    int pending_units;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int bytes_sent = 0;

    utf8_to_utf16_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .push            (push),
        .full            (full),
        .o_code_unit     (o_code_unit),
        .o_end_of_string (o_end_of_string),
        .empty           (empty),
        .pop             (pop)
    );

    utf16_unit_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .push            (push),
        .full            (full),
        .o_code_unit     (o_code_unit),
        .o_end_of_string (o_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_fail_count    (fail_count),
        .o_pending       (pending_units)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one byte and hold it until full is seen low
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // encode cp in nbytes, keeping only the first keep continuation bytes
    task automatic send_sequence(input int nbytes, input logic [20:0] cp, input int keep);
        logic [7:0] lead;
        int         shift;
        case (nbytes)
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        send_byte(lead);
        for (int j = 0; j < keep; j++) begin
            shift = 6 * (nbytes - 2 - j);
            send_byte({2'b10, 6'((cp >> shift) & 21'h3F)});
        end
    endtask

    task automatic send_random_text();
        int          pick;
        int          len;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        cp   = 21'($urandom());
        len  = $urandom_range(2, 4);
        if (pick < 8)
            send_byte(8'h00);
        else if (pick < 38)
            send_byte(8'($urandom_range(1, 127)));
        else if (pick < 85)
            send_sequence(len, cp, len - 1);
        else if (pick < 93)
            send_sequence(len, cp, $urandom_range(0, len - 2));
        else
            send_byte(8'($urandom_range(1, 255)));
    endtask

    initial begin
        logic [7:0] directed_bytes[$];
        int         phase_end;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ASCII extremes, 2/3/4-byte forms, stray continuation, invalid leads,
        // a cut-short sequence, a code point above the Unicode range, flush on zero
        directed_bytes = {8'h41, 8'h7F, 8'h01, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                          8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hF8, 8'hC3,
                          8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hE2, 8'h82, 8'h00,
                          8'h00};
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // no idling, with a long receiver hold-off to back up the input
        idle_pct  = 0;
        stall_pct = 0;
        hold_left <= 60;
        phase_end = bytes_sent + 84;
        while (bytes_sent < phase_end)
            send_random_text();

        idle_pct  = 66;
        phase_end = bytes_sent + 84;
        while (bytes_sent < phase_end)
            send_random_text();

        idle_pct  = 0;
        stall_pct = 66;
        phase_end = bytes_sent + 84;
        while (bytes_sent < phase_end)
            send_random_text();

        idle_pct  = 13;
        stall_pct = 13;
        phase_end = bytes_sent + 84;
        while (bytes_sent < phase_end)
            send_random_text();

        // close the last string so any pending sequence is flushed
        send_byte(8'h00);

        push <= 1'b0;
        @(posedge i_clk);
        while (pending_units != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
